@@ rtl/pidc_pkg.sv @@
`default_nettype none
package pidc_pkg;

   localparam int GAIN_W  = 16;
   localparam int LIMIT_W = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DATA_W  = 16;
   localparam int ERR_W   = DATA_W + 1;
   localparam int ACC_W   = 24;
   localparam int FRAC_W  = 8;

   localparam logic [GAIN_W-1:0]  KP_RESET   = 16'd7168;
   localparam logic [GAIN_W-1:0]  KI_RESET   = 16'd128;
   localparam logic [GAIN_W-1:0]  KD_RESET   = 16'd2560;
   localparam logic [LIMIT_W-1:0] ILIM_RESET = 15'd2000;
   localparam logic [LIMIT_W-1:0] OLIM_RESET = 15'd10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_GAIN        = 3'd0,
      CSR_KI_GAIN        = 3'd1,
      CSR_KD_GAIN        = 3'd2,
      CSR_INTEGRAL_LIMIT = 3'd3,
      CSR_OUTPUT_LIMIT   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  kp_gain;
      logic [GAIN_W-1:0]  ki_gain;
      logic [GAIN_W-1:0]  kd_gain;
      logic [LIMIT_W-1:0] integral_limit;
      logic [LIMIT_W-1:0] output_limit;
   } pidc_cfg_type;

endpackage
`default_nettype wire

@@ rtl/pidc_cfg.sv @@
`default_nettype none
module pidc_cfg (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [pidc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pidc_pkg::CSR_DATA_W-1:0]  csr_data,
   output pidc_pkg::pidc_cfg_type                cfg
);
   import pidc_pkg::*;

   pidc_cfg_type cfg_ff;
   pidc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KP_GAIN:        cfg_in.kp_gain        = csr_data;
            CSR_KI_GAIN:        cfg_in.ki_gain        = csr_data;
            CSR_KD_GAIN:        cfg_in.kd_gain        = csr_data;
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_data[LIMIT_W-1:0];
            CSR_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_data[LIMIT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain        <= KP_RESET;
         cfg_ff.ki_gain        <= KI_RESET;
         cfg_ff.kd_gain        <= KD_RESET;
         cfg_ff.integral_limit <= ILIM_RESET;
         cfg_ff.output_limit   <= OLIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ rtl/pidc_core.sv @@
`default_nettype none
module pidc_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pidc_pkg::pidc_cfg_type              cfg,
   input  wire logic                                step,
   input  wire logic signed [pidc_pkg::DATA_W-1:0]  measured_value,
   input  wire logic signed [pidc_pkg::DATA_W-1:0]  setpoint,
   output logic signed [pidc_pkg::DATA_W-1:0]       drive
);
   import pidc_pkg::*;

   localparam int PROD_W = ERR_W + GAIN_W + 1;
   localparam int ISUM_W = PROD_W + 1;
   localparam int DIFF_W = ERR_W + 1;
   localparam int DPRD_W = DIFF_W + GAIN_W + 1;
   localparam int SUM_W  = DPRD_W - FRAC_W + 2;

   logic signed [ACC_W-1:0]  integral_acc_ff, integral_acc_in;
   logic signed [ERR_W-1:0]  previous_error_ff;

   logic signed [ERR_W-1:0]  err;
   logic signed [PROD_W-1:0] p_prod, i_prod;
   logic signed [ISUM_W-1:0] i_sum, i_lim, i_clamped;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DPRD_W-1:0] d_prod;
   logic signed [SUM_W-1:0]  sum, o_lim, o_clamped;

   always_comb begin
      err    = ERR_W'({setpoint[DATA_W-1], setpoint})
             - ERR_W'({measured_value[DATA_W-1], measured_value});
      p_prod = PROD_W'(err) * PROD_W'($signed({1'b0, cfg.kp_gain}));
      i_prod = PROD_W'(err) * PROD_W'($signed({1'b0, cfg.ki_gain}));
      diff   = DIFF_W'(err) - DIFF_W'(previous_error_ff);
      d_prod = DPRD_W'(diff) * DPRD_W'($signed({1'b0, cfg.kd_gain}));

      i_sum = ISUM_W'(integral_acc_ff) + ISUM_W'(i_prod);
      i_lim = $signed({{(ISUM_W-LIMIT_W-FRAC_W){1'b0}}, cfg.integral_limit,
                       {FRAC_W{1'b0}}});
      if (i_sum >= i_lim)
         i_clamped = i_lim;
      else if (i_sum <= -i_lim)
         i_clamped = -i_lim;
      else
         i_clamped = i_sum;
      integral_acc_in = i_clamped[ACC_W-1:0];

      // floor shifts: take the high bits of the exact products
      sum = SUM_W'($signed(p_prod[PROD_W-1:FRAC_W]))
          + SUM_W'($signed(integral_acc_in[ACC_W-1:FRAC_W]))
          + SUM_W'($signed(d_prod[DPRD_W-1:FRAC_W]));
      o_lim = $signed({{(SUM_W-LIMIT_W){1'b0}}, cfg.output_limit});
      if (sum >= o_lim)
         o_clamped = o_lim;
      else if (sum <= -o_lim)
         o_clamped = -o_lim;
      else
         o_clamped = sum;
      drive = o_clamped[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_acc_ff   <= '0;
         previous_error_ff <= '0;
      end else if (step) begin
         integral_acc_ff   <= integral_acc_in;
         previous_error_ff <= err;
      end
   end

endmodule
`default_nettype wire

@@ rtl/pid_controller_clamped_top.sv @@
// An accepted req_ transaction moves through the input and result registers
// to rsp_valid. Throughput: 1 transaction per cycle while rsp_stall is low;
// the integral loop is in the single pass between input and result registers.
// Reset (synchronous, active high) clears the valids, the integral and the
// previous error, and loads the gain and limit registers with their defaults.
`default_nettype none
module pid_controller_clamped_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [pidc_pkg::DATA_W-1:0]  req_measured_value,
   input  wire logic signed [pidc_pkg::DATA_W-1:0]  req_setpoint,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [pidc_pkg::DATA_W-1:0]       rsp_drive,
   input  wire logic                                csr_wr_en,
   input  wire logic [pidc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pidc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pidc_pkg::*;

   pidc_cfg_type cfg;

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [DATA_W-1:0] s1_meas_ff, s1_setp_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_drive_ff;
   logic signed [DATA_W-1:0] drive;
   logic                     out_load, step;

   pidc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pidc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .step           (step),
      .measured_value (s1_meas_ff),
      .setpoint       (s1_setp_ff),
      .drive          (drive)
   );

   assign out_load     = !rsp_valid_ff || !rsp_stall;
   assign step         = s1_valid_ff && out_load;
   assign req_stall    = s1_valid_ff && !out_load;
   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_meas_ff <= req_measured_value;
         s1_setp_ff <= req_setpoint;
      end
      if (step) begin
         rsp_drive_ff <= drive;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule
`default_nettype wire

@@ rtl/pidc_checker.sv @@
`default_nettype none
module pidc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [pidc_pkg::DATA_W-1:0]  rsp_drive,
   input wire logic                                csr_wr_en,
   input wire logic [pidc_pkg::CSR_IDX_W-1:0]      csr_index,
   input wire logic [pidc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pidc_pkg::*;

   logic [LIMIT_W-1:0]       olim_ff;
   logic signed [DATA_W:0]   olim_s;
   logic signed [DATA_W:0]   drive_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         olim_ff <= OLIM_RESET;
      end else if (csr_wr_en && csr_index == CSR_OUTPUT_LIMIT) begin
         olim_ff <= csr_data[LIMIT_W-1:0];
      end
   end

   assign olim_s  = $signed({2'b00, olim_ff});
   assign drive_s = (DATA_W+1)'(rsp_drive);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive))
      else $error("stalled response changed");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (drive_s <= olim_s) && (drive_s >= -olim_s))
      else $error("drive outside output limit");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response missing two cycles after accept");

   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("request stalled while output free");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind pid_controller_clamped_top pidc_checker u_pidc_checker (.*);
`default_nettype wire

@@ tb/sv/pid_controller_clamped_top_tb.sv @@
module pid_controller_clamped_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pidc_pkg::*;

   localparam int PIPE_LATENCY = 2;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_ITEMS  = 206;

   typedef struct packed {
      logic [DATA_W-1:0] measured;
      logic [DATA_W-1:0] setpoint;
   } ctrl_sample_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [DATA_W-1:0]  req_measured_value;
   logic signed [DATA_W-1:0]  req_setpoint;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [DATA_W-1:0]  rsp_drive;
   logic                      csr_wr_en;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;

   pid_controller_clamped_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_measured_value (req_measured_value),
      .req_setpoint       (req_setpoint),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive          (rsp_drive),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   ctrl_sample_type           sample_queue[$];
   logic signed [DATA_W-1:0]  drive_expected[$];
   ctrl_sample_type           next_sample;
   logic signed [DATA_W-1:0]  drive_want;
   int                        send_idle_pct;
   int                        recv_stall_pct;
   int                        mismatch_count;
   int unsigned               cycle_count;

   // controller model: gains, limits and loop state
   logic [GAIN_W-1:0]   kp_q8;
   logic [GAIN_W-1:0]   ki_q8;
   logic [GAIN_W-1:0]   kd_q8;
   logic [LIMIT_W-1:0]  ilim_int;
   logic [LIMIT_W-1:0]  olim_int;
   longint              integ_q8;
   longint              prev_err;

   function automatic longint clamp_sym(longint x, longint lim);
      if (x >= lim) return lim;
      if (x <= -lim) return -lim;
      return x;
   endfunction

   function automatic logic signed [DATA_W-1:0] next_drive(logic signed [DATA_W-1:0] meas,
                                                          logic signed [DATA_W-1:0] setp);
      longint err;
      longint p_term;
      longint d_term;
      longint sum;
      err      = longint'(setp) - longint'(meas);
      p_term   = (err * longint'(kp_q8)) >>> FRAC_W;
      integ_q8 = clamp_sym(integ_q8 + err * longint'(ki_q8), longint'(ilim_int) * 256);
      d_term   = ((err - prev_err) * longint'(kd_q8)) >>> FRAC_W;
      prev_err = err;
      sum      = clamp_sym(p_term + (integ_q8 >>> FRAC_W) + d_term, longint'(olim_int));
      return sum[DATA_W-1:0];
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_sample = sample_queue.pop_front();
            req_valid          <= 1'b1;
            req_measured_value <= next_sample.measured;
            req_setpoint       <= next_sample.setpoint;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            drive_expected.push_back(next_drive(req_measured_value, req_setpoint));
         if (rsp_valid && !rsp_stall) begin
            if (drive_expected.size() == 0) begin
               $error("drive: no transaction expected, got %0d", rsp_drive);
               mismatch_count <= mismatch_count + 1;
            end else begin
               drive_want = drive_expected.pop_front();
               if (rsp_drive !== drive_want) begin
                  $error("drive: expected %0d, actual %0d", drive_want, rsp_drive);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_KP_GAIN:        kp_q8    = value;
         CSR_KI_GAIN:        ki_q8    = value;
         CSR_KD_GAIN:        kd_q8    = value;
         CSR_INTEGRAL_LIMIT: ilim_int = value[LIMIT_W-1:0];
         CSR_OUTPUT_LIMIT:   olim_int = value[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_gains(logic [CSR_DATA_W-1:0] kp, logic [CSR_DATA_W-1:0] ki,
                            logic [CSR_DATA_W-1:0] kd, logic [CSR_DATA_W-1:0] ilim,
                            logic [CSR_DATA_W-1:0] olim);
      write_csr(CSR_KP_GAIN, kp);
      write_csr(CSR_KI_GAIN, ki);
      write_csr(CSR_KD_GAIN, kd);
      write_csr(CSR_INTEGRAL_LIMIT, ilim);
      write_csr(CSR_OUTPUT_LIMIT, olim);
   endtask

   task automatic add_sample(logic [DATA_W-1:0] meas, logic [DATA_W-1:0] setp);
      ctrl_sample_type s;
      s.measured = meas;
      s.setpoint = setp;
      sample_queue.push_back(s);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || drive_expected.size() != 0)
         @(negedge clock);
   endtask

   task automatic drain();
      wait_idle();
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return CSR_DATA_W'($urandom_range(0, 1023));
         3:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(0, 16383));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_limit();
      logic [LIMIT_W-1:0] lim;
      case ($urandom_range(0, 5))
         0:       lim = '0;
         1:       lim = '1;
         2:       lim = LIMIT_W'($urandom_range(0, 255));
         3:       lim = LIMIT_W'($urandom);
         default: lim = LIMIT_W'($urandom_range(500, 12000));
      endcase
      return {1'($urandom_range(0, 1)), lim};
   endfunction

   task automatic run_random_phase(int count);
      logic [DATA_W-1:0] target;
      logic [DATA_W-1:0] delta;
      set_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
      write_csr(CSR_IDX_W'($urandom_range(int'(CSR_OUTPUT_LIMIT) + 1, (1 << CSR_IDX_W) - 1)),
                CSR_DATA_W'($urandom));
      target = DATA_W'($urandom);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0)
            target = DATA_W'($urandom);
         delta = DATA_W'($urandom_range(0, 1023) - 512);
         case ($urandom_range(0, 9))
            0, 1, 2: add_sample(DATA_W'($urandom), DATA_W'($urandom));
            3:       add_sample(target, target);
            default: add_sample(target + delta, target);
         endcase
         // sender holds off mid-phase until the pipeline is empty
         if (i == count / 2)
            wait_idle();
      end
      drain();
   endtask

   initial begin
      int send_pct[4];
      int stall_pct[4];
      send_pct  = '{0, 53, 0, 26};
      stall_pct = '{0, 0, 53, 26};
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_measured_value = '0;
      req_setpoint       = '0;
      rsp_stall          = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      mismatch_count     = 0;
      cycle_count        = 0;
      kp_q8    = KP_RESET;
      ki_q8    = KI_RESET;
      kd_q8    = KD_RESET;
      ilim_int = ILIM_RESET;
      olim_int = OLIM_RESET;
      integ_q8 = 0;
      prev_err = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset gains, full-scale errors
      add_sample(16'h0000, 16'h0000);
      add_sample(16'h8000, 16'h7FFF);
      add_sample(16'h7FFF, 16'h8000);
      add_sample(16'h8000, 16'h8000);
      add_sample(16'h7FFF, 16'h7FFF);
      add_sample(16'd100, 16'd95);
      drain();

      // unity P only, output landing exactly on the limit; upper bits ignored
      set_gains(16'd256, 16'd0, 16'd0, 16'h8000, 16'h8064);
      for (int i = int'(CSR_OUTPUT_LIMIT) + 1; i < (1 << CSR_IDX_W); i++)
         write_csr(CSR_IDX_W'(i), CSR_DATA_W'($urandom));
      add_sample(16'd0, 16'd100);
      add_sample(16'd0, 16'hFF9C);
      add_sample(16'd0, 16'd99);
      add_sample(16'd0, 16'hFF9B);
      drain();

      // zero limits with maximum gains
      set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
      add_sample(16'h8000, 16'h7FFF);
      add_sample(16'h7FFF, 16'h8000);
      add_sample(16'd0, 16'd1);
      drain();

      // integral hitting a limit of one exactly
      set_gains(16'd0, 16'd256, 16'd0, 16'h8001, 16'h7FFF);
      add_sample(16'd0, 16'd1);
      add_sample(16'd0, 16'd1);
      add_sample(16'd0, 16'hFFFD);
      add_sample(16'd0, 16'd0);
      drain();

      // everything at maximum
      set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
      add_sample(16'h8000, 16'h7FFF);
      add_sample(16'h7FFF, 16'h8000);
      add_sample(16'h7FFF, 16'h8000);
      add_sample(16'd0, 16'd0);
      drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pct[p];
         recv_stall_pct = stall_pct[p];
         run_random_phase(PHASE_ITEMS);
         run_random_phase(PHASE_ITEMS);
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drain();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
